FILE: rtl/greedy_element_coloring_top_macros.svh
// Assertion macros for the greedy element coloring block.
// Used by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef GREEDY_ELEMENT_COLORING_TOP_MACROS_SVH
`define GREEDY_ELEMENT_COLORING_TOP_MACROS_SVH

// same-cycle implication
`define GEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gec_pkg.sv
// Shared types and constants for the greedy element coloring block.
// No dependencies; imported by every module of the block.
package gec_pkg;

  localparam int NODE_W     = 12;
  localparam int TOTAL_W    = 4;
  localparam int COLOR_W    = 4;
  localparam int USED_W     = 5;
  localparam int MAX_NODES  = 8;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  typedef logic [MAX_NODES-1:0][NODE_W-1:0] node_vec_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED1,
    ST_RED2,
    ST_READ,
    ST_PICK,
    ST_WRITE,
    ST_DONE
  } gec_state_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic [USED_W-1:0]  colors_used;
    logic               overflow;
    logic [COLOR_W-1:0] color;
  } res_t;

endpackage

FILE: rtl/gec_slot_reduce.sv
// Two-stage reduction of a node index modulo the node count.
// Depends on gec_pkg; reciprocal multiply, then back-multiply and one correction.
module gec_slot_reduce #(
  parameter int NUM_NODES = 4096
) (
  input  logic                      clk,
  input  logic [gec_pkg::NODE_W-1:0] raw,
  output logic [gec_pkg::NODE_W-1:0] slot
);
  import gec_pkg::*;

  localparam int SHIFT   = 2 * NODE_W;
  localparam int RECIP   = (1 << SHIFT) / NUM_NODES;
  localparam int PROD_W  = SHIFT + NODE_W - 2;
  localparam int QUOT_W  = PROD_W - SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot_r;
  logic [NODE_W-1:0] raw_q_r;
  logic [31:0]       back;
  logic [NODE_W-1:0] rem;
  logic [NODE_W-1:0] slot_r;

  assign prod = PROD_W'(raw) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    quot_r  <= prod[PROD_W-1:SHIFT];
    raw_q_r <= raw;
  end

  assign back = 32'(quot_r) * 32'(NUM_NODES);
  assign rem  = raw_q_r - back[NODE_W-1:0];

  always_ff @(posedge clk) begin
    if (32'(rem) >= 32'(NUM_NODES)) begin
      slot_r <= rem - NODE_W'(NUM_NODES);
    end else begin
      slot_r <= rem;
    end
  end

  assign slot = slot_r;

endmodule

FILE: rtl/gec_mask_mem.sv
// Single-port node colour mask memory with registered read.
// Depends on gec_pkg for the port control struct.
module gec_mask_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  gec_pkg::mem_ctl_t ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);
  import gec_pkg::*;

  logic [DATA_W-1:0] mask_mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mask_mem[addr] <= wdata;
      end
      rdata_r <= mask_mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/gec_ctrl.sv
// Sequencer for greedy colouring: clearing pass, mask reads, colour pick, mask writes.
// Depends on gec_pkg and greedy_element_coloring_top_macros.svh.
module gec_ctrl #(
  parameter int NUM_NODES         = 4096,
  parameter int COLOR_LIMIT       = 16,
  parameter int NODES_PER_ELEMENT = 8,
  parameter int ADDR_W            = 12
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  gec_pkg::node_vec_t                              nodes,
  input  logic [gec_pkg::TOTAL_W-1:0]                     node_total,
  output logic [NODES_PER_ELEMENT-1:0][gec_pkg::NODE_W-1:0] raw,
  input  logic [NODES_PER_ELEMENT-1:0][gec_pkg::NODE_W-1:0] slot,
  output gec_pkg::mem_ctl_t                               mem_ctl,
  output logic [ADDR_W-1:0]                               mem_addr,
  output logic [COLOR_LIMIT-1:0]                          mem_wdata,
  input  logic [COLOR_LIMIT-1:0]                          mem_rdata,
  output logic                                            res_valid,
  input  logic                                            res_ready,
  output gec_pkg::res_t                                   res
);
  import gec_pkg::*;
  `include "greedy_element_coloring_top_macros.svh"

  localparam int LANE_W = $clog2(NODES_PER_ELEMENT + 1);
  localparam int LIDX_W = $clog2(NODES_PER_ELEMENT);
  localparam int CIDX_W = $clog2(COLOR_LIMIT);
  localparam int TOT_W  = $clog2(COLOR_LIMIT + 1);

  gec_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]      clr_r;
  logic [LANE_W-1:0]      idx_r;
  logic [LANE_W-1:0]      cnt_r;
  logic [LANE_W-1:0]      cnt_in;
  logic                   rd_pend_r;
  logic [LIDX_W-1:0]      rd_idx_r;
  logic [COLOR_LIMIT-1:0] mask_r [NODES_PER_ELEMENT];
  logic [CIDX_W-1:0]      chosen_r;
  logic                   found_r;
  logic [TOT_W-1:0]       total_r;
  logic [NODES_PER_ELEMENT-1:0][NODE_W-1:0] raw_r;

  logic [COLOR_LIMIT-1:0] taken;
  logic [CIDX_W-1:0]      pick_idx;
  logic                   pick_found;
  logic [TOT_W-1:0]       pick_next;
  logic [COLOR_LIMIT-1:0] bit_mask;
  logic                   rd_issue;
  logic [LIDX_W-1:0]      lane;

  assign in_ready = (state_r == ST_IDLE);
  assign raw      = raw_r;
  assign cnt_in   = (node_total > TOTAL_W'(NODES_PER_ELEMENT)) ?
                    LANE_W'(NODES_PER_ELEMENT) : LANE_W'(node_total);
  assign lane     = idx_r[LIDX_W-1:0];
  assign rd_issue = (state_r == ST_READ) && (idx_r < cnt_r);
  assign bit_mask = COLOR_LIMIT'(1) << chosen_r;

  always_comb begin
    taken = '0;
    for (int l = 0; l < NODES_PER_ELEMENT; l++) begin
      if (LANE_W'(l) < cnt_r) begin
        taken = taken | mask_r[l];
      end
    end
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int c = COLOR_LIMIT - 1; c >= 0; c--) begin
      if (!taken[c]) begin
        pick_idx   = CIDX_W'(c);
        pick_found = 1'b1;
      end
    end
    pick_next = TOT_W'(pick_idx) + TOT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(NUM_NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RED1;
        end
      end
      ST_RED1: state_nxt = ST_RED2;
      ST_RED2: state_nxt = ST_READ;
      ST_READ: begin
        if (idx_r == cnt_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_found && (cnt_r != '0)) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        if (idx_r == cnt_r - LANE_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = '0;
    mem_wdata = '0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.en = 1'b1;
        mem_ctl.we = 1'b1;
        mem_addr   = clr_r;
      end
      ST_READ: begin
        mem_ctl.en = rd_issue;
        mem_addr   = ADDR_W'(slot[lane]);
      end
      ST_WRITE: begin
        mem_ctl.en = 1'b1;
        mem_ctl.we = 1'b1;
        mem_addr   = ADDR_W'(slot[lane]);
        mem_wdata  = mask_r[lane] | bit_mask;
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.color       = COLOR_W'(chosen_r);
  assign res.overflow    = !found_r;
  assign res.colors_used = USED_W'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      idx_r     <= '0;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_issue;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (in_valid && in_ready) begin
        cnt_r <= cnt_in;
      end
      if ((state_r == ST_RED2) || (state_r == ST_PICK)) begin
        idx_r <= '0;
      end else if ((state_r == ST_READ) || (state_r == ST_WRITE)) begin
        idx_r <= idx_r + LANE_W'(1);
      end
      if (state_r == ST_PICK) begin
        found_r <= pick_found;
        if (pick_found && (pick_next > total_r)) begin
          total_r <= pick_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= lane;
    if (in_valid && in_ready) begin
      for (int l = 0; l < NODES_PER_ELEMENT; l++) begin
        raw_r[l] <= nodes[l];
      end
    end
    if (rd_pend_r) begin
      mask_r[rd_idx_r] <= mem_rdata;
    end
    if (state_r == ST_PICK) begin
      chosen_r <= pick_idx;
    end
  end

  `GEC_ASSERT_NOW(a_we_phase, mem_ctl.we, (state_r == ST_CLEAR) || (state_r == ST_WRITE), "mask write outside clear or write phase")
  `GEC_ASSERT_NEXT(a_accept_red, in_valid && in_ready, state_r == ST_RED1, "accepted item did not start reduction")
  `GEC_ASSERT_NOW(a_ovf_zero, res_valid && res.overflow, res.color == '0, "overflow result with non-zero colour")
  `GEC_ASSERT_NOW(a_write_found, state_r == ST_WRITE, found_r && (idx_r < cnt_r), "mask write without a free colour")

endmodule

FILE: rtl/greedy_element_coloring_top.sv
// Greedy first-fit element colouring, top level: stream ports, index reduction, mask memory.
// Depends on gec_pkg, gec_slot_reduce, gec_mask_mem and gec_ctrl.
// Per element: index reduction, n mask reads, colour pick, then n mask writes, where
// n = used node count (0..8); no writes on overflow. A new element is taken only in idle.
// Reset: synchronous, active low; a clearing pass over all NUM_NODES addresses zeroes the
// mask memory, in_tready stays low until it completes.
module greedy_element_coloring_top #(
  parameter int NUM_NODES         = 4096,
  parameter int COLOR_LIMIT       = 16,
  parameter int NODES_PER_ELEMENT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_a, node_b, node_c, node_d, node_e, node_f, node_g, node_h, node_total, zero pad
  input  logic [gec_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // color, colors_used, zero pad
  output logic [gec_pkg::OUT_DATA_W-1:0]   out_tdata,
  // overflow
  output logic                             out_tuser
);
  import gec_pkg::*;

  localparam int ADDR_W = $clog2(NUM_NODES);

  node_vec_t              nodes;
  logic [TOTAL_W-1:0]     node_total;
  logic [NODES_PER_ELEMENT-1:0][NODE_W-1:0] raw;
  logic [NODES_PER_ELEMENT-1:0][NODE_W-1:0] slot;
  mem_ctl_t               mem_ctl;
  logic [ADDR_W-1:0]      mem_addr;
  logic [COLOR_LIMIT-1:0] mem_wdata;
  logic [COLOR_LIMIT-1:0] mem_rdata;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   out_valid_r;
  res_t                   out_res_r;

  always_comb begin
    for (int l = 0; l < MAX_NODES; l++) begin
      nodes[l] = in_tdata[l*NODE_W +: NODE_W];
    end
    node_total = in_tdata[MAX_NODES*NODE_W +: TOTAL_W];
  end

  for (genvar l = 0; l < NODES_PER_ELEMENT; l++) begin : g_lane
    gec_slot_reduce #(
      .NUM_NODES(NUM_NODES)
    ) u_reduce (
      .clk (clk),
      .raw (raw[l]),
      .slot(slot[l])
    );
  end

  gec_mask_mem #(
    .DEPTH (NUM_NODES),
    .ADDR_W(ADDR_W),
    .DATA_W(COLOR_LIMIT)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  gec_ctrl #(
    .NUM_NODES        (NUM_NODES),
    .COLOR_LIMIT      (COLOR_LIMIT),
    .NODES_PER_ELEMENT(NODES_PER_ELEMENT),
    .ADDR_W           (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .nodes     (nodes),
    .node_total(node_total),
    .raw       (raw),
    .slot      (slot),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - USED_W - COLOR_W)'(0), out_res_r.colors_used,
                       out_res_r.color};
  assign out_tuser  = out_res_r.overflow;

endmodule

FILE: tb/sv/tb_greedy_element_coloring_top.sv
// Testbench for greedy_element_coloring_top: first-fit colouring of mesh elements
// checked against a per-node colour mask predictor. Depends on gec_pkg and the RTL.
// Stream driver and monitor are clocked always blocks; stimulus is queued up front.
module tb_greedy_element_coloring_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gec_pkg::*;

  localparam int NUM_NODES    = 4096;
  localparam int COLORS       = 16;
  localparam int NODES_BITS   = MAX_NODES * NODE_W;
  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE       = 2 * MAX_NODES + 7 + 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               overflow;
    logic [USED_W-1:0]  used;
  } coloring_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic [IN_DATA_W-1:0] element_q[$];
  coloring_t            color_q[$];
  logic [COLORS-1:0]    node_masks [NUM_NODES];
  logic [USED_W-1:0]    colors_in_use;
  int                   accepted = 0;
  int                   mismatches = 0;
  int                   cycle_count = 0;
  coloring_t            want;
  coloring_t            got;

  greedy_element_coloring_top #(
    .NUM_NODES(NUM_NODES),
    .COLOR_LIMIT(COLORS),
    .NODES_PER_ELEMENT(MAX_NODES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coloring_t first_fit_color(input logic [IN_DATA_W-1:0] word);
    node_vec_t         nodes;
    logic [TOTAL_W-1:0] total;
    int                used_nodes;
    int                pick;
    logic [COLORS-1:0] taken;
    coloring_t         r;
    nodes = word[NODES_BITS-1:0];
    total = word[NODES_BITS +: TOTAL_W];
    used_nodes = (total > MAX_NODES) ? MAX_NODES : int'(total);
    taken = '0;
    pick = -1;
    for (int i = 0; i < used_nodes; i++) taken |= node_masks[nodes[i]];
    for (int c = COLORS - 1; c >= 0; c--) if (!taken[c]) pick = c;
    if (pick < 0) begin
      r.color = '0;
      r.overflow = 1'b1;
    end else begin
      for (int i = 0; i < used_nodes; i++) node_masks[nodes[i]][pick] = 1'b1;
      if (pick + 1 > int'(colors_in_use)) colors_in_use = USED_W'(pick + 1);
      r.color = COLOR_W'(pick);
      r.overflow = 1'b0;
    end
    r.used = colors_in_use;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_element(input node_vec_t nodes,
                                                        input logic [TOTAL_W-1:0] total);
    return {{(IN_DATA_W - NODES_BITS - TOTAL_W){1'b0}}, total, nodes};
  endfunction

  function automatic node_vec_t random_nodes();
    node_vec_t v;
    for (int k = 0; k < MAX_NODES; k++) v[k] = NODE_W'($urandom_range(NUM_NODES - 1));
    return v;
  endfunction

  function automatic int sender_gap_pct(input int done);
    return (done < 600) ? 10 : (done < 1200) ? 68 : 0;
  endfunction

  function automatic int receiver_stall_pct(input int done);
    return (done < 600) ? 68 : (done < 1200) ? 10 : 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        color_q = {color_q, first_fit_color(in_tdata)};
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (element_q.size() != 0 && $urandom_range(99) >= sender_gap_pct(accepted)) begin
          in_tdata <= element_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.color = out_tdata[COLOR_W-1:0];
      got.used = out_tdata[COLOR_W +: USED_W];
      got.overflow = out_tuser;
      if (color_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: color %0d overflow %0b used %0d",
                   got.color, got.overflow, got.used);
      end else begin
        want = color_q.pop_front();
        if (got.color != want.color || got.overflow != want.overflow
            || got.used != want.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected color %0d overflow %0b used %0d, got %0d %0b %0d",
                     want.color, want.overflow, want.used,
                     got.color, got.overflow, got.used);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= receiver_stall_pct(accepted));
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    node_vec_t          nodes;
    logic [TOTAL_W-1:0] total;
    int                 base;
    int                 pool;
    int                 burst;
    int                 directed;
    bit                 noisy;

    foreach (node_masks[i]) node_masks[i] = '0;
    colors_in_use = '0;

    // lowest node, reused, then an element with no nodes
    nodes = '0;
    element_q = {element_q, make_element(nodes, 4'd1)};
    element_q = {element_q, make_element(nodes, 4'd1)};
    element_q = {element_q, make_element(random_nodes(), 4'd0)};
    // highest node repeated, full count and saturating count
    nodes = {MAX_NODES{12'hFFF}};
    element_q = {element_q, make_element(nodes, 4'd8)};
    element_q = {element_q, make_element(nodes, 4'd15)};
    // exhaust every colour on one node, then overflow
    nodes = {MAX_NODES{12'd100}};
    for (int c = 0; c < COLORS; c++) element_q = {element_q, make_element(nodes, 4'd1)};
    element_q = {element_q, make_element(nodes, 4'd9)};
    directed = element_q.size();

    while (element_q.size() < directed + RANDOM_ITEMS) begin
      base = $urandom_range(NUM_NODES - 1);
      pool = $urandom_range(3, 48);
      burst = $urandom_range(8, 64);
      noisy = ($urandom_range(9) == 0);
      repeat (burst) begin
        nodes = random_nodes();
        if ($urandom_range(9) == 0) total = TOTAL_W'($urandom_range(15));
        else total = TOTAL_W'($urandom_range(1, MAX_NODES));
        if (!noisy)
          for (int k = 0; k < MAX_NODES; k++)
            if ($urandom_range(19) != 0) nodes[k] = NODE_W'(base + $urandom_range(pool - 1));
        element_q = {element_q, make_element(nodes, total)};
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (element_q.size() != 0 || in_tvalid || color_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && color_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
